### hw/rtl/tsort_pkg.sv
// package for the dfs topological sort block
// types, opcodes, mark codes and state encoding; no dependencies
`default_nettype none
package tsort_pkg;
   localparam int MaxNodes = 64;
   localparam int NodeW = 6;
   localparam int CountW = 7;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_ADD   = 2'd1,
      OP_SORT  = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      MARK_WHITE = 2'd0,
      MARK_GREY  = 2'd1,
      MARK_BLACK = 2'd2
   } mark_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_MARKCLR,
      ST_ROOT,
      ST_ROOTCHK,
      ST_TOPRD,
      ST_SCAN,
      ST_VISIT,
      ST_FINISH,
      ST_EMITRD,
      ST_EMIT,
      ST_CYCLE
   } state_type;
endpackage
`default_nettype wire

### hw/rtl/tsort_if.sv
// valid/ready channel interfaces for the sort block
// node fields are fixed at six bits; does not use tsort_pkg
`default_nettype none
interface tsort_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [5:0] from_node;
   logic [5:0] to_node;
   modport source (output valid, opcode, from_node, to_node, input ready);
   modport sink (input valid, opcode, from_node, to_node, output ready);
endinterface

interface tsort_rsp_if;
   logic       valid;
   logic       ready;
   logic [5:0] node;
   logic       is_last;
   logic       acyclic;
   modport source (output valid, node, is_last, acyclic, input ready);
   modport sink (input valid, node, is_last, acyclic, output ready);
endinterface
`default_nettype wire

### hw/rtl/tsort_scan.sv
// lowest-set-bit search over one masked adjacency row
// combinational priority unit shared by every scan step; uses tsort_pkg
`default_nettype none
module tsort_scan #(
   parameter int MAX_NODES = tsort_pkg::MaxNodes
) (
   input  wire logic [MAX_NODES-1:0]          row,
   input  wire logic [$clog2(MAX_NODES):0]    start_pos,
   input  wire logic [$clog2(MAX_NODES):0]    limit,
   output logic                               found,
   output logic [$clog2(MAX_NODES)-1:0]       pos
);
   import tsort_pkg::*;
   localparam int IW = $clog2(MAX_NODES);
   logic [MAX_NODES-1:0] rem;

   always_comb begin
      for (int i = 0; i < MAX_NODES; i++) begin
         rem[i] = row[i] && (i >= int'(start_pos)) && (i < int'(limit));
      end
      found = |rem;
      pos = '0;
      for (int i = MAX_NODES - 1; i >= 0; i--) begin
         if (rem[i]) begin
            pos = IW'(i);
         end
      end
   end
endmodule
`default_nettype wire

### hw/rtl/topological_sort_cycle_check.sv
// Add edge sets one adjacency bit when both nodes are in range; clear
// sweeps the adjacency memory while the input is held off. Sort: clears
// every mark, tries each root, scans neighbors and records finished nodes,
// then emits the result items (or a single cycle item) with receiver stalls;
// one item at a time, input waits for the last result. Reset: synchronous,
// clears control, num_nodes to 64, and sweeps the adjacency memory before the first item is taken.
`default_nettype none
module topological_sort_cycle_check #(
   parameter int MAX_NODES = tsort_pkg::MaxNodes
) (
   input  wire logic clock,
   input  wire logic reset,
   tsort_req_if.sink   req,
   tsort_rsp_if.source rsp,
   input  wire logic       csr_write_enable,
   input  wire logic [6:0] csr_write_data
);
   import tsort_pkg::*;
   localparam int IW = $clog2(MAX_NODES);
   localparam int CW = IW + 1;

   logic [MAX_NODES-1:0] adj_mem [MAX_NODES];
   logic [1:0]           mark_mem [MAX_NODES];
   logic [2*IW:0]        stk_mem [MAX_NODES];
   logic [IW-1:0]        fin_mem [MAX_NODES];

   state_type state_ff, state_in;
   logic [6:0]    nodes_ff;
   logic [CW-1:0] n_eff;
   logic [IW-1:0] idx_ff, idx_in;
   logic [CW-1:0] depth_ff, depth_in;
   logic [CW-1:0] fcnt_ff, fcnt_in;
   logic [CW-1:0] emit_ff, emit_in;
   logic [IW-1:0] u_ff, u_in;
   logic [CW-1:0] p_ff, p_in;
   logic [IW-1:0] v_ff, v_in;
   logic [MAX_NODES-1:0] row_ff;
   logic [1:0]    mark_rd_ff;
   logic [2*IW:0] stk_rd_ff;
   logic [IW-1:0] fin_rd_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [IW-1:0] rsp_node_ff, rsp_node_in;
   logic          rsp_last_ff, rsp_last_in;
   logic          rsp_acyc_ff, rsp_acyc_in;

   logic          adj_we, adj_clr, mark_we, stk_we, fin_we;
   logic [IW-1:0] adj_addr, mark_addr, mark_raddr, stk_addr, stk_raddr;
   logic [1:0]    mark_wd;
   logic [2*IW:0] stk_wd;
   logic          scan_found;
   logic [IW-1:0] scan_pos;
   logic          accept;

   always_comb begin
      if (nodes_ff == 7'd0) n_eff = CW'(1);
      else if (int'(nodes_ff) > MAX_NODES) n_eff = CW'(MAX_NODES);
      else n_eff = CW'(nodes_ff);
   end

   tsort_scan #(.MAX_NODES(MAX_NODES)) u_scan (
      .row(row_ff), .start_pos(p_ff), .limit(n_eff),
      .found(scan_found), .pos(scan_pos)
   );

   assign req.ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign accept = req.valid && req.ready;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.node = rsp_node_ff;
   assign rsp.is_last = rsp_last_ff;
   assign rsp.acyclic = rsp_acyc_ff;

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      depth_in = depth_ff;
      fcnt_in = fcnt_ff;
      emit_in = emit_ff;
      u_in = u_ff;
      p_in = p_ff;
      v_in = v_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_node_in = rsp_node_ff;
      rsp_last_in = rsp_last_ff;
      rsp_acyc_in = rsp_acyc_ff;
      adj_we = 1'b0;
      adj_clr = 1'b0;
      adj_addr = idx_ff;
      mark_we = 1'b0;
      mark_addr = idx_ff;
      mark_wd = MARK_WHITE;
      mark_raddr = idx_ff;
      stk_we = 1'b0;
      stk_addr = IW'(depth_ff);
      stk_wd = '0;
      stk_raddr = IW'(depth_ff - CW'(1));
      fin_we = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            idx_in = '0;
            if (accept) begin
               unique case (opcode_type'(req.opcode))
                  OP_CLEAR: state_in = ST_CLEAR;
                  OP_ADD: begin
                     adj_addr = req.from_node;
                     adj_we = (CW'(req.from_node) < n_eff) && (CW'(req.to_node) < n_eff);
                  end
                  OP_SORT: state_in = ST_MARKCLR;
                  OP_NONE: state_in = ST_IDLE;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_CLEAR: begin
            adj_clr = 1'b1;
            idx_in = idx_ff + IW'(1);
            if (int'(idx_ff) == MAX_NODES - 1) state_in = ST_IDLE;
         end
         ST_MARKCLR: begin
            mark_we = 1'b1;
            idx_in = idx_ff + IW'(1);
            fcnt_in = '0;
            if (int'(idx_ff) == MAX_NODES - 1) begin
               idx_in = '0;
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            state_in = ST_ROOTCHK;
         end
         ST_ROOTCHK: begin
            if (mark_rd_ff == MARK_WHITE) begin
               mark_we = 1'b1;
               mark_wd = MARK_GREY;
               stk_we = 1'b1;
               stk_addr = '0;
               stk_wd = {idx_ff, CW'(0)};
               depth_in = CW'(1);
               state_in = ST_TOPRD;
            end else if (CW'(idx_ff) + CW'(1) >= n_eff) begin
               emit_in = '0;
               state_in = ST_EMITRD;
            end else begin
               idx_in = idx_ff + IW'(1);
               state_in = ST_ROOT;
            end
         end
         ST_TOPRD: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            u_in = stk_rd_ff[2*IW:CW];
            p_in = stk_rd_ff[CW-1:0];
            state_in = ST_VISIT;
         end
         ST_VISIT: begin
            mark_raddr = scan_pos;
            if (!scan_found) begin
               state_in = ST_FINISH;
            end else begin
               v_in = scan_pos;
               stk_we = 1'b1;
               stk_addr = IW'(depth_ff - CW'(1));
               stk_wd = {u_ff, CW'(scan_pos) + CW'(1)};
               p_in = CW'(scan_pos) + CW'(1);
               state_in = ST_CYCLE;
            end
         end
         ST_CYCLE: begin
            if (mark_rd_ff == MARK_GREY) begin
               rsp_valid_in = 1'b1;
               rsp_node_in = '0;
               rsp_last_in = 1'b1;
               rsp_acyc_in = 1'b0;
               state_in = ST_IDLE;
            end else if (mark_rd_ff == MARK_WHITE && int'(depth_ff) < MAX_NODES) begin
               mark_we = 1'b1;
               mark_addr = v_ff;
               mark_wd = MARK_GREY;
               stk_we = 1'b1;
               stk_wd = {v_ff, CW'(0)};
               depth_in = depth_ff + CW'(1);
               state_in = ST_TOPRD;
            end else begin
               state_in = ST_TOPRD;
            end
         end
         ST_FINISH: begin
            mark_we = 1'b1;
            mark_addr = u_ff;
            mark_wd = MARK_BLACK;
            fin_we = (int'(fcnt_ff) < MAX_NODES);
            if (fin_we) fcnt_in = fcnt_ff + CW'(1);
            depth_in = depth_ff - CW'(1);
            if (depth_ff == CW'(1)) begin
               if (CW'(idx_ff) + CW'(1) >= n_eff) begin
                  emit_in = '0;
                  state_in = ST_EMITRD;
               end else begin
                  idx_in = idx_ff + IW'(1);
                  state_in = ST_ROOT;
               end
            end else begin
               state_in = ST_TOPRD;
            end
            stk_raddr = IW'(depth_ff - CW'(2));
         end
         ST_EMITRD: begin
            if (!rsp_valid_ff || rsp.ready) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            rsp_valid_in = 1'b1;
            rsp_node_in = (n_eff - CW'(1) - emit_ff < fcnt_ff) ? fin_rd_ff : '0;
            rsp_last_in = (emit_ff == n_eff - CW'(1));
            rsp_acyc_in = 1'b1;
            emit_in = emit_ff + CW'(1);
            state_in = rsp_last_in ? ST_IDLE : ST_EMITRD;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         nodes_ff <= 7'd64;
         idx_ff <= '0;
         rsp_valid_ff <= 1'b0;
         depth_ff <= '0;
         fcnt_ff <= '0;
         emit_ff <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         depth_ff <= depth_in;
         fcnt_ff <= fcnt_in;
         emit_ff <= emit_in;
         if (csr_write_enable) nodes_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      u_ff <= u_in;
      p_ff <= p_in;
      v_ff <= v_in;
      rsp_node_ff <= rsp_node_in;
      rsp_last_ff <= rsp_last_in;
      rsp_acyc_ff <= rsp_acyc_in;
   end

   // adjacency memory: single bit set on add, row read for scan
   always_ff @(posedge clock) begin
      if (reset || adj_clr) begin
         adj_mem[adj_addr] <= '0;
      end else if (adj_we) begin
         adj_mem[adj_addr][req.to_node] <= 1'b1;
      end
      row_ff <= adj_mem[stk_rd_ff[2*IW:CW]];
   end

   always_ff @(posedge clock) begin
      if (mark_we) mark_mem[mark_addr] <= mark_wd;
      mark_rd_ff <= mark_mem[mark_raddr];
   end

   always_ff @(posedge clock) begin
      if (stk_we) stk_mem[stk_addr] <= stk_wd;
      stk_rd_ff <= stk_mem[stk_raddr];
   end

   always_ff @(posedge clock) begin
      if (fin_we) fin_mem[IW'(fcnt_ff)] <= u_ff;
      fin_rd_ff <= fin_mem[IW'(n_eff - CW'(1) - emit_ff)];
   end

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req.ready) else $error("ready while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> rsp.valid) else $error("item dropped");
   a_depth: assert property (@(posedge clock) disable iff (reset)
      int'(depth_ff) <= MAX_NODES) else $error("stack overflow");
   a_cycle_last: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.acyclic) |-> rsp.is_last) else $error("cycle item not last");
endmodule
`default_nettype wire
